// ===== hdl/ircl_pkg.sv =====
// Shared types and constants for the IP range country lookup unit.
package ircl_pkg;

  localparam int TABLE_DEPTH = 4096;
  localparam int IDX_W       = $clog2(TABLE_DEPTH);
  localparam int CNT_W       = IDX_W + 1;
  localparam int ADDR_W      = 32;
  localparam int CODE_W      = 24;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_INSERT = 2'd1,
    OP_LOOKUP = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    STS_OK        = 2'd0,
    STS_FULL      = 2'd1,
    STS_NOT_FOUND = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    RES_DONE,
    RES_FULL,
    RES_MISS,
    RES_LOOKUP
  } res_kind_t;

  typedef struct packed {
    logic [CODE_W-1:0] code;
    logic [ADDR_W-1:0] count;
    logic [ADDR_W-1:0] start;
  } entry_t;

  typedef struct packed {
    logic      load;
    logic      clr;
    logic      srch_rd;
    logic      srch_step;
    logic      sh_rd;
    logic      sh_wr;
    logic      ins_wr;
    logic      lk_rd;
    logic      res_load;
    res_kind_t kind;
  } cmd_t;

  typedef struct packed {
    logic srch_done;
    logic sh_done;
    logic full;
    logic lo_zero;
    logic out_free;
  } sts_t;

endpackage

// ===== hdl/ircl_ctrl.sv =====
// Sequencer for clear, insert and lookup operations on the range table.
module ircl_ctrl import ircl_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic [1:0] in_operation,
  output logic       in_stall,
  input  sts_t       sts,
  output cmd_t       cmd
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SRCH_RD,
    ST_SRCH_CMP,
    ST_SH_RD,
    ST_SH_WR,
    ST_DONE
  } state_t;

  state_t    state_r, state_nxt;
  res_kind_t kind_r, kind_nxt;
  op_t       op_r, op_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    kind_nxt  = kind_r;
    op_nxt    = op_r;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          op_nxt   = op_t'(in_operation);
          case (op_t'(in_operation))
            OP_CLEAR: begin
              cmd.clr   = 1'b1;
              kind_nxt  = RES_DONE;
              state_nxt = ST_DONE;
            end
            OP_INSERT: begin
              if (sts.full) begin
                kind_nxt  = RES_FULL;
                state_nxt = ST_DONE;
              end else begin
                state_nxt = ST_SRCH_RD;
              end
            end
            OP_LOOKUP: begin
              state_nxt = ST_SRCH_RD;
            end
            default: begin
              kind_nxt  = RES_DONE;
              state_nxt = ST_DONE;
            end
          endcase
        end
      end
      ST_SRCH_RD: begin
        if (sts.srch_done) begin
          if (op_r == OP_INSERT) begin
            state_nxt = ST_SH_RD;
          end else if (sts.lo_zero) begin
            kind_nxt  = RES_MISS;
            state_nxt = ST_DONE;
          end else begin
            cmd.lk_rd = 1'b1;
            kind_nxt  = RES_LOOKUP;
            state_nxt = ST_DONE;
          end
        end else begin
          cmd.srch_rd = 1'b1;
          state_nxt   = ST_SRCH_CMP;
        end
      end
      ST_SRCH_CMP: begin
        cmd.srch_step = 1'b1;
        state_nxt     = ST_SRCH_RD;
      end
      ST_SH_RD: begin
        if (sts.sh_done) begin
          cmd.ins_wr = 1'b1;
          kind_nxt   = RES_DONE;
          state_nxt  = ST_DONE;
        end else begin
          cmd.sh_rd = 1'b1;
          state_nxt = ST_SH_WR;
        end
      end
      ST_SH_WR: begin
        cmd.sh_wr = 1'b1;
        state_nxt = ST_SH_RD;
      end
      ST_DONE: begin
        if (sts.out_free) begin
          cmd.res_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
    cmd.kind = kind_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      kind_r  <= RES_DONE;
      op_r    <= OP_CLEAR;
    end else begin
      state_r <= state_nxt;
      kind_r  <= kind_nxt;
      op_r    <= op_nxt;
    end
  end

  assign in_stall = (state_r != ST_IDLE);

endmodule

// ===== hdl/ircl_dp.sv =====
// Range table memory, search bounds, shift index and result register.
module ircl_dp import ircl_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [1:0]        in_operation,
  input  logic [ADDR_W-1:0] in_range_start,
  input  logic [ADDR_W-1:0] in_range_count,
  input  logic [CODE_W-1:0] in_country_code,
  input  logic [ADDR_W-1:0] in_lookup_address,
  input  cmd_t              cmd,
  output sts_t              sts,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [1:0]        out_status,
  output logic [CODE_W-1:0] out_found_code,
  output logic [ADDR_W-1:0] out_found_start,
  output logic [ADDR_W-1:0] out_found_count
);

  entry_t tbl_r [TABLE_DEPTH];
  entry_t rd_data_r;
  entry_t new_r;

  logic [CNT_W-1:0]  entries_used_r;
  logic [CNT_W-1:0]  lo_r;
  logic [CNT_W-1:0]  hi_r;
  logic [CNT_W-1:0]  i_r;
  logic [CNT_W-1:0]  mid;
  logic [ADDR_W-1:0] key_r;

  logic              out_valid_r;
  logic [1:0]        out_status_r;
  logic [CODE_W-1:0] out_code_r;
  logic [ADDR_W-1:0] out_start_r;
  logic [ADDR_W-1:0] out_count_r;

  logic              rd_en;
  logic [IDX_W-1:0]  rd_addr;
  logic              wr_en;
  logic [IDX_W-1:0]  wr_addr;
  entry_t            wr_data;
  logic [ADDR_W:0]   range_end;
  logic              hit;
  logic [1:0]        res_status;
  entry_t            res_entry;

  assign mid = lo_r + ((hi_r - lo_r) >> 1);

  always_comb begin
    rd_en   = cmd.srch_rd | cmd.sh_rd | cmd.lk_rd;
    rd_addr = mid[IDX_W-1:0];
    if (cmd.sh_rd) begin
      rd_addr = i_r[IDX_W-1:0] - IDX_W'(1);
    end else if (cmd.lk_rd) begin
      rd_addr = lo_r[IDX_W-1:0] - IDX_W'(1);
    end
    wr_en   = cmd.sh_wr | cmd.ins_wr;
    wr_addr = cmd.sh_wr ? i_r[IDX_W-1:0] : lo_r[IDX_W-1:0];
    wr_data = cmd.sh_wr ? rd_data_r : new_r;
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= tbl_r[rd_addr];
    end
    if (wr_en) begin
      tbl_r[wr_addr] <= wr_data;
    end
  end

  assign range_end = {1'b0, rd_data_r.start} + {1'b0, rd_data_r.count};
  assign hit       = ({1'b0, key_r} < range_end);

  always_comb begin
    res_status = STS_OK;
    res_entry  = '0;
    case (cmd.kind)
      RES_FULL: begin
        res_status = STS_FULL;
      end
      RES_MISS: begin
        res_status = STS_NOT_FOUND;
      end
      RES_LOOKUP: begin
        if (hit) begin
          res_entry = rd_data_r;
        end else begin
          res_status = STS_NOT_FOUND;
        end
      end
      default: begin
        res_status = STS_OK;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key_r       <= (op_t'(in_operation) == OP_INSERT) ? in_range_start : in_lookup_address;
      new_r.start <= in_range_start;
      new_r.count <= in_range_count;
      new_r.code  <= in_country_code;
    end
    if (cmd.res_load) begin
      out_status_r <= res_status;
      out_code_r   <= res_entry.code;
      out_start_r  <= res_entry.start;
      out_count_r  <= res_entry.count;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      entries_used_r <= '0;
      lo_r           <= '0;
      hi_r           <= '0;
      i_r            <= '0;
      out_valid_r    <= 1'b0;
    end else begin
      if (cmd.load) begin
        lo_r <= '0;
        hi_r <= entries_used_r;
        i_r  <= entries_used_r;
      end
      if (cmd.clr) begin
        entries_used_r <= '0;
      end
      if (cmd.srch_step) begin
        if (rd_data_r.start <= key_r) begin
          lo_r <= mid + CNT_W'(1);
        end else begin
          hi_r <= mid;
        end
      end
      if (cmd.sh_wr) begin
        i_r <= i_r - CNT_W'(1);
      end
      if (cmd.ins_wr) begin
        entries_used_r <= entries_used_r + CNT_W'(1);
      end
      if (cmd.res_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign sts.srch_done = (lo_r >= hi_r);
  assign sts.sh_done   = (i_r == lo_r);
  assign sts.full      = (entries_used_r == CNT_W'(TABLE_DEPTH));
  assign sts.lo_zero   = (lo_r == '0);
  assign sts.out_free  = !out_valid_r || !out_stall;

  assign out_valid       = out_valid_r;
  assign out_status      = out_status_r;
  assign out_found_code  = out_code_r;
  assign out_found_start = out_start_r;
  assign out_found_count = out_count_r;

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    entries_used_r <= CNT_W'(TABLE_DEPTH))
    else $error("entry count beyond table depth");

  a_bounds_order: assert property (@(posedge clk) disable iff (!rst_n)
    lo_r <= hi_r)
    else $error("search bounds crossed");

  a_shift_above_pos: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.sh_wr |-> (i_r > lo_r))
    else $error("shift index at or below insert position");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.res_load |-> (!out_valid_r || !out_stall))
    else $error("pending result overwritten");

  a_insert_room: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.ins_wr |-> (entries_used_r < CNT_W'(TABLE_DEPTH)))
    else $error("insert into full table");

endmodule

// ===== hdl/ip_range_country_lookup_unit.sv =====
// Top level of the IP range country lookup unit.
//
// Holds up to 4096 IPv4 ranges sorted by start address in a single-port table
// memory with a registered read. One operation is in flight at a time; each
// binary search step is a table read followed by a compare, and an insert then
// shifts each entry above the insert position up by one (a read, then a write)
// before it writes the new entry. A clear or an insert into a full table skips
// the search and goes straight to the result. A new beat is accepted while the
// previous result still waits on the output register.
module ip_range_country_lookup_unit import ircl_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        in_operation,
  input  logic [ADDR_W-1:0] in_range_start,
  input  logic [ADDR_W-1:0] in_range_count,
  input  logic [CODE_W-1:0] in_country_code,
  input  logic [ADDR_W-1:0] in_lookup_address,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [1:0]        out_status,
  output logic [CODE_W-1:0] out_found_code,
  output logic [ADDR_W-1:0] out_found_start,
  output logic [ADDR_W-1:0] out_found_count
);

  cmd_t cmd;
  sts_t sts;

  ircl_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_operation (in_operation),
    .in_stall     (in_stall),
    .sts          (sts),
    .cmd          (cmd)
  );

  ircl_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_operation      (in_operation),
    .in_range_start    (in_range_start),
    .in_range_count    (in_range_count),
    .in_country_code   (in_country_code),
    .in_lookup_address (in_lookup_address),
    .cmd               (cmd),
    .sts               (sts),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_status        (out_status),
    .out_found_code    (out_found_code),
    .out_found_start   (out_found_start),
    .out_found_count   (out_found_count)
  );

endmodule
